>>> rtl/restricted_circular_deque_macros.svh
// Assertion shorthands for the deque checker.
`ifndef RESTRICTED_CIRCULAR_DEQUE_MACROS_SVH
`define RESTRICTED_CIRCULAR_DEQUE_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while reset is asserted.
`define RCD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while reset is asserted.
`define RCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/rcd_pkg.sv
package rcd_pkg;

  localparam int unsigned DATA_W = 32;

  typedef enum logic [1:0] {
    REQ_PUSH_RIGHT = 2'd0,
    REQ_PUSH_LEFT  = 2'd1,
    REQ_POP_LEFT   = 2'd2,
    REQ_POP_RIGHT  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_DONE        = 2'd0,
    ST_OVERFLOW    = 2'd1,
    ST_UNDERFLOW   = 2'd2,
    ST_NOT_ALLOWED = 2'd3
  } status_e;

  typedef enum logic {
    MODE_IN_RESTRICTED  = 1'b0,
    MODE_OUT_RESTRICTED = 1'b1
  } mode_e;

  // Per-word outcome from the index logic.
  typedef struct packed {
    status_e status;
    logic    pop_ok;
  } ctrl_res_t;

endpackage

>>> rtl/rcd_mem.sv
module rcd_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned IDX_W = $clog2(DEPTH)
) (
  input  logic                      clk_i,
  input  logic                      wr_en_i,
  input  logic [IDX_W-1:0]          wr_addr_i,
  input  logic [rcd_pkg::DATA_W-1:0] wr_data_i,
  input  logic                      rd_en_i,
  input  logic [IDX_W-1:0]          rd_addr_i,
  output logic [rcd_pkg::DATA_W-1:0] rd_data_o
);
  import rcd_pkg::*;

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read data only moves on a read, so it holds while the result stalls.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/rcd_ctrl.sv
module rcd_ctrl #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned IDX_W = $clog2(DEPTH)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  input  rcd_pkg::req_e      req_type_i,
  input  rcd_pkg::mode_e     mode_i,
  output logic               wr_en_o,
  output logic [IDX_W-1:0]   wr_addr_o,
  output logic               rd_en_o,
  output logic [IDX_W-1:0]   rd_addr_o,
  output rcd_pkg::ctrl_res_t res_o
);
  import rcd_pkg::*;

  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(DEPTH - 1);

  function automatic logic [IDX_W-1:0] wrap_up(input logic [IDX_W-1:0] idx);
    return (idx == LastIdx) ? '0 : idx + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] wrap_down(input logic [IDX_W-1:0] idx);
    return (idx == '0) ? LastIdx : idx - 1'b1;
  endfunction

  logic [IDX_W-1:0] left_q, left_d;
  logic [IDX_W-1:0] right_q, right_d;
  logic             empty_q, empty_d;
  logic             full;
  logic             not_allowed;
  logic [IDX_W-1:0] right_up;
  logic [IDX_W-1:0] left_down;

  assign right_up    = wrap_up(right_q);
  assign left_down   = wrap_down(left_q);
  assign full        = !empty_q && (right_up == left_q);
  assign not_allowed = ((mode_i == MODE_IN_RESTRICTED) && (req_type_i == REQ_PUSH_LEFT)) ||
                       ((mode_i == MODE_OUT_RESTRICTED) && (req_type_i == REQ_POP_RIGHT));

  always_comb begin
    left_d       = left_q;
    right_d      = right_q;
    empty_d      = empty_q;
    wr_en_o      = 1'b0;
    wr_addr_o    = right_up;
    rd_en_o      = 1'b0;
    rd_addr_o    = left_q;
    res_o.status = ST_DONE;
    res_o.pop_ok = 1'b0;
    if (not_allowed) begin
      res_o.status = ST_NOT_ALLOWED;
    end else begin
      case (req_type_i)
        REQ_PUSH_RIGHT, REQ_PUSH_LEFT: begin
          if (full) begin
            res_o.status = ST_OVERFLOW;
          end else begin
            wr_en_o = 1'b1;
            if (empty_q) begin
              // first word lands at slot 0 from the right, last slot from the left
              wr_addr_o = (req_type_i == REQ_PUSH_RIGHT) ? '0 : LastIdx;
              left_d    = wr_addr_o;
              right_d   = wr_addr_o;
              empty_d   = 1'b0;
            end else if (req_type_i == REQ_PUSH_RIGHT) begin
              wr_addr_o = right_up;
              right_d   = right_up;
            end else begin
              wr_addr_o = left_down;
              left_d    = left_down;
            end
          end
        end
        REQ_POP_LEFT, REQ_POP_RIGHT: begin
          if (empty_q) begin
            res_o.status = ST_UNDERFLOW;
          end else begin
            rd_en_o      = 1'b1;
            res_o.pop_ok = 1'b1;
            rd_addr_o    = (req_type_i == REQ_POP_LEFT) ? left_q : right_q;
            if (left_q == right_q) begin
              empty_d = 1'b1;
              left_d  = '0;
              right_d = '0;
            end else if (req_type_i == REQ_POP_LEFT) begin
              left_d = wrap_up(left_q);
            end else begin
              right_d = wrap_down(right_q);
            end
          end
        end
        default: begin
          res_o.status = ST_NOT_ALLOWED;
        end
      endcase
    end
    if (!req_valid_i) begin
      wr_en_o = 1'b0;
      rd_en_o = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q  <= '0;
      right_q <= '0;
      empty_q <= 1'b1;
    end else if (req_valid_i) begin
      left_q  <= left_d;
      right_q <= right_d;
      empty_q <= empty_d;
    end
  end

endmodule

>>> rtl/restricted_circular_deque.sv
// Channel   Dir  Fields (tdata / tuser, lowest bit first)
// s_axis    in   tdata: push_value[31:0] (signed)   tuser: req_type[1:0]
// m_axis    out  tdata: pop_value[31:0] (signed)    tuser: status[1:0]
// cfg       in   cfg_data_i: restrict_mode (0 input-, 1 output-restricted)
//
// One word is accepted per cycle unless a stalled result holds s_axis_tready_o
// low; its result is in the output register on the next cycle.
// The index update and the store write/read all happen at the accept edge;
// the store's registered read port supplies pop_value.
// Reset clears the indices, the empty flag, the mode and the output valid.
// The store is not cleared. A stalled result holds and drops s_axis_tready_o.
module restricted_circular_deque #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // request stream
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  logic [31:0]                s_axis_tdata_i,  // [31:0] push_value
  input  logic [1:0]                 s_axis_tuser_i,  // [1:0] req_type
  // result stream
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  output logic [31:0]                m_axis_tdata_o,  // [31:0] pop_value
  output logic [1:0]                 m_axis_tuser_o,  // [1:0] status
  // mode register write
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic                       cfg_data_i
);
  import rcd_pkg::*;

  localparam int unsigned IdxW = $clog2(DEPTH);

  logic              s_accept;
  mode_e             mode_q;
  logic              out_valid_q;
  status_e           status_q;
  logic              pop_ok_q;
  ctrl_res_t         ctrl_res;
  logic              wr_en;
  logic [IdxW-1:0]   wr_addr;
  logic              rd_en;
  logic [IdxW-1:0]   rd_addr;
  logic [DATA_W-1:0] rd_data;

  // Input side is free whenever the output register is empty or draining.
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IN_RESTRICTED;
    end else if (cfg_valid_i) begin
      mode_q <= mode_e'(cfg_data_i);
    end
  end

  rcd_ctrl #(
    .DEPTH (DEPTH),
    .IDX_W (IdxW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_accept),
    .req_type_i  (req_e'(s_axis_tuser_i)),
    .mode_i      (mode_q),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .res_o       (ctrl_res)
  );

  rcd_mem #(
    .DEPTH (DEPTH),
    .IDX_W (IdxW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (s_axis_tdata_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Result register: status and pop flag; the popped word sits in the store's
  // read register, loaded on the same edge.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      out_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      status_q <= ctrl_res.status;
      pop_ok_q <= ctrl_res.pop_ok;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = pop_ok_q ? rd_data : '0;
  assign m_axis_tuser_o  = status_q;

endmodule

>>> rtl/rcd_checker.sv
`include "restricted_circular_deque_macros.svh"

module rcd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic [1:0]  m_axis_tuser_o
);
  import rcd_pkg::*;

  logic        in_take;
  logic        out_stall;
  logic        rejected;
  logic [33:0] out_word;

  assign in_take   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_stall = m_axis_tvalid_o && !m_axis_tready_i;
  assign rejected  = m_axis_tvalid_o && (m_axis_tuser_o != ST_DONE);
  assign out_word  = {m_axis_tuser_o, m_axis_tdata_o};

  `RCD_ASSERT_NEXT(a_hold, out_stall, m_axis_tvalid_o && $stable(out_word), "stalled word moved")
  `RCD_ASSERT_SAME(a_backpressure, out_stall, !s_axis_tready_o, "word taken while result stalled")
  `RCD_ASSERT_NEXT(a_result_follows, in_take, m_axis_tvalid_o, "accepted word gave no result")
  `RCD_ASSERT_SAME(a_reject_zero, rejected, m_axis_tdata_o == '0, "rejected request carries data")

endmodule

bind restricted_circular_deque rcd_checker u_rcd_checker (.*);

>>> verif/restricted_circular_deque_checker.sv
module restricted_circular_deque_checker #(
  parameter int unsigned DEPTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  input  logic              s_axis_tready_i,
  input  logic [31:0]       s_axis_tdata_i,   // [31:0] push_value
  input  logic [1:0]        s_axis_tuser_i,   // [1:0] req_type
  input  logic              m_axis_tvalid_i,
  input  logic              m_axis_tready_i,
  input  logic [31:0]       m_axis_tdata_i,   // [31:0] pop_value
  input  logic [1:0]        m_axis_tuser_i,   // [1:0] status
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic              cfg_data_i,
  output int                fail_count_o,
  output int                pending_o
);
  import rcd_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0] pop_value;
    status_e           status;
  } deque_outcome_t;

  // Shadow copy of the deque.
  logic [DATA_W-1:0] shadow_store [DEPTH];
  int unsigned       left_idx;
  int unsigned       right_idx;
  bit                is_empty;
  mode_e             mode;

  deque_outcome_t    deque_outcomes [$];
  int                mismatches;

  function automatic int unsigned idx_up(int unsigned i);
    return (i == DEPTH - 1) ? 0 : i + 1;
  endfunction

  function automatic int unsigned idx_down(int unsigned i);
    return (i == 0) ? DEPTH - 1 : i - 1;
  endfunction

  // Apply one request to the shadow deque and return the word it produces.
  function automatic deque_outcome_t apply_deque_op(req_e op, logic [DATA_W-1:0] word);
    deque_outcome_t res;
    bit             full;
    full = !is_empty && (idx_up(right_idx) == left_idx);
    res  = '{pop_value: '0, status: ST_DONE};
    if ((mode == MODE_IN_RESTRICTED && op == REQ_PUSH_LEFT) ||
        (mode == MODE_OUT_RESTRICTED && op == REQ_POP_RIGHT)) begin
      res.status = ST_NOT_ALLOWED;
    end else if (op == REQ_PUSH_RIGHT || op == REQ_PUSH_LEFT) begin
      if (full) begin
        res.status = ST_OVERFLOW;
      end else if (is_empty) begin
        left_idx  = (op == REQ_PUSH_RIGHT) ? 0 : DEPTH - 1;
        right_idx = left_idx;
        is_empty  = 1'b0;
        shadow_store[left_idx] = word;
      end else if (op == REQ_PUSH_RIGHT) begin
        right_idx = idx_up(right_idx);
        shadow_store[right_idx] = word;
      end else begin
        left_idx = idx_down(left_idx);
        shadow_store[left_idx] = word;
      end
    end else if (is_empty) begin
      res.status = ST_UNDERFLOW;
    end else begin
      res.pop_value = (op == REQ_POP_LEFT) ? shadow_store[left_idx] : shadow_store[right_idx];
      if (left_idx == right_idx) begin
        is_empty  = 1'b1;
        left_idx  = 0;
        right_idx = 0;
      end else if (op == REQ_POP_LEFT) begin
        left_idx = idx_up(left_idx);
      end else begin
        right_idx = idx_down(right_idx);
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    deque_outcome_t want;
    if (!rst_ni) begin
      left_idx   = 0;
      right_idx  = 0;
      is_empty   = 1'b1;
      mode       = MODE_IN_RESTRICTED;
      mismatches = 0;
      deque_outcomes.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (deque_outcomes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result word with none pending: pop_value=%h status=%0d",
                     $realtime, m_axis_tdata_i, m_axis_tuser_i);
        end else begin
          want = deque_outcomes.pop_front();
          if (m_axis_tdata_i !== want.pop_value || m_axis_tuser_i !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch: pop_value exp %h got %h, status exp %0d got %0d",
                       $realtime, want.pop_value, m_axis_tdata_i, want.status,
                       m_axis_tuser_i);
          end
        end
      end
      // a word taken on the same edge as a mode write still sees the old mode
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        deque_outcomes.push_back(apply_deque_op(req_e'(s_axis_tuser_i), s_axis_tdata_i));
      end
      if (cfg_valid_i && cfg_ready_i) begin
        mode = mode_e'(cfg_data_i);
      end
      fail_count_o <= mismatches;
      pending_o    <= deque_outcomes.size();
    end
  end

endmodule

>>> verif/restricted_circular_deque_tb.sv
module restricted_circular_deque_tb;
  import rcd_pkg::*;

  localparam int unsigned DEPTH       = 64;
  localparam int          HOLD_CYCLES = 300;  // long receiver hold-off

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i;   // [31:0] push_value
  logic [1:0]  s_axis_tuser_i;   // [1:0] req_type
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [31:0] m_axis_tdata_o;   // [31:0] pop_value
  logic [1:0]  m_axis_tuser_o;   // [1:0] status
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_data_i;

  int          fail_count;
  int          pending;

  // Knobs for the request driver and the result sink.
  int          src_idle_pct;
  int          sink_stall_pct;
  int          holds_asked;
  int          holds_done;
  mode_e       cur_mode;

  restricted_circular_deque #(.DEPTH(DEPTH)) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  restricted_circular_deque_checker #(.DEPTH(DEPTH)) checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_i (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_i (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_i  (m_axis_tdata_o),
    .m_axis_tuser_i  (m_axis_tuser_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Hard stop, well beyond the slowest legal run.
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

  // Result sink: random back-pressure, plus a long hold-off on request so the
  // output register stays full and the block has to drop s_axis_tready_o.
  initial begin
    m_axis_tready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (holds_done < holds_asked) begin
        m_axis_tready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        holds_done++;
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // Mostly random payloads, with the sign and all-ones/all-zeros corners mixed in.
  function automatic logic [31:0] pick_word();
    logic [31:0] corners [4];
    corners = '{32'h0000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff};
    if ($urandom_range(9) == 0) return corners[$urandom_range(3)];
    return $urandom();
  endfunction

  // Offer one word; an optional idle gap goes in front of it. Returns on the
  // edge where it is taken, with tvalid still high.
  task automatic send_word(req_e op, logic [31:0] word);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < src_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= word;
    s_axis_tuser_i  <= op;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  // Stop offering, wait for the last result, then let the pipe go quiet.
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Mode change; only issued while the block is idle.
  task automatic write_mode(mode_e m);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= m;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cur_mode = m;
    @(posedge clk_i);
  endtask

  // Random traffic in fill and drain bursts, so the deque swings between
  // empty and full and both indices wrap. A few words are requests that the
  // current mode rejects.
  task automatic run_random(int n_words);
    int   burst_left;
    bit   filling;
    int   r;
    req_e op;
    burst_left = 0;
    filling    = 1'b1;
    for (int i = 0; i < n_words; i++) begin
      if (burst_left == 0) begin
        filling    = ~filling;
        burst_left = $urandom_range(10, 130);
      end
      burst_left--;
      r = $urandom_range(99);
      if (r < 6) begin
        op = (cur_mode == MODE_IN_RESTRICTED) ? REQ_PUSH_LEFT : REQ_POP_RIGHT;
      end else if ($urandom_range(99) < (filling ? 85 : 15)) begin
        op = (cur_mode == MODE_IN_RESTRICTED || $urandom_range(1)) ? REQ_PUSH_RIGHT
                                                                    : REQ_PUSH_LEFT;
      end else begin
        op = (cur_mode == MODE_OUT_RESTRICTED || $urandom_range(1)) ? REQ_POP_LEFT
                                                                     : REQ_POP_RIGHT;
      end
      send_word(op, pick_word());
    end
  endtask

  initial begin
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= REQ_PUSH_RIGHT;
    cfg_valid_i     <= 1'b0;
    cfg_data_i      <= MODE_IN_RESTRICTED;
    rst_ni          <= 1'b0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    holds_asked    = 0;
    holds_done     = 0;
    cur_mode       = MODE_IN_RESTRICTED;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Input-restricted: underflow at both ends, rejected left insert,
    // corner payloads, removal from each end, last entry taken.
    write_mode(MODE_IN_RESTRICTED);
    send_word(REQ_POP_LEFT,   32'h1234_5678);
    send_word(REQ_POP_RIGHT,  32'hffff_ffff);
    send_word(REQ_PUSH_LEFT,  32'hdead_beef);
    send_word(REQ_PUSH_RIGHT, 32'h8000_0000);
    send_word(REQ_PUSH_RIGHT, 32'h7fff_ffff);
    send_word(REQ_PUSH_RIGHT, 32'hffff_ffff);
    send_word(REQ_PUSH_RIGHT, 32'h0000_0000);
    send_word(REQ_POP_RIGHT,  32'h0000_0000);
    send_word(REQ_POP_LEFT,   32'h0000_0000);
    send_word(REQ_POP_LEFT,   32'h0000_0000);
    send_word(REQ_POP_RIGHT,  32'h0000_0000);
    send_word(REQ_POP_LEFT,   32'h0000_0000);
    drain();

    // Output-restricted: left insert into empty starts at the top index,
    // right removal rejected, drain to empty from the left.
    write_mode(MODE_OUT_RESTRICTED);
    send_word(REQ_PUSH_LEFT,  32'h5555_aaaa);
    send_word(REQ_PUSH_LEFT,  32'haaaa_5555);
    send_word(REQ_PUSH_RIGHT, 32'h0f0f_f0f0);
    send_word(REQ_POP_RIGHT,  32'hffff_ffff);
    send_word(REQ_POP_LEFT,   32'h0000_0000);
    send_word(REQ_POP_LEFT,   32'h0000_0000);
    send_word(REQ_POP_LEFT,   32'h0000_0000);
    send_word(REQ_POP_LEFT,   32'h0000_0000);
    drain();

    // Random phases with different idling, alternating the mode so the
    // contents carry across mode changes.
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 67; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 67; end
        default: begin src_idle_pct = 15; sink_stall_pct = 15; end
      endcase
      write_mode((p % 2 == 0) ? MODE_OUT_RESTRICTED : MODE_IN_RESTRICTED);
      run_random(360);
      drain();
    end

    // Back-pressure: sink holds off for a long stretch while words keep coming.
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    holds_asked    = 1;
    @(posedge clk_i);
    run_random(80);
    drain();

    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/rcd_pkg.sv
rtl/rcd_mem.sv
rtl/rcd_ctrl.sv
rtl/restricted_circular_deque.sv
rtl/rcd_checker.sv
verif/restricted_circular_deque_checker.sv
verif/restricted_circular_deque_tb.sv
